// ===== rtl/gcm_pkg.sv =====
// Shared constants, types and helpers for the gradient color map.
`default_nettype none
package gcm_pkg;

   localparam int SAMPLE_BITS        = 24;
   localparam int MAX_STOPS          = 8;
   localparam int FRAC_BITS          = 16;
   localparam int DIV_BITS_PER_STAGE = 2;
   localparam int DIV_STAGES         = FRAC_BITS / DIV_BITS_PER_STAGE;
   localparam int REM_BITS           = SAMPLE_BITS + 1;
   localparam int STOP_IDX_BITS      = $clog2(MAX_STOPS);
   localparam int COUNT_BITS         = 4;
   localparam int COLOR_BITS         = 24;
   localparam int CHAN_BITS          = 8;
   localparam int STOP_REGS          = MAX_STOPS / 2;
   localparam int CSR_DATA_BITS      = 2 * COLOR_BITS;
   localparam int CSR_INDEX_BITS     = 3;
   localparam int SCALED_BITS        = FRAC_BITS + STOP_IDX_BITS;

   // Register indexes of the configuration port
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_RANGE_MIN  = 3'd0,
      CSR_RANGE_MAX  = 3'd1,
      CSR_STOP_COUNT = 3'd2,
      CSR_STOPS_0_1  = 3'd3,
      CSR_STOPS_2_3  = 3'd4,
      CSR_STOPS_4_5  = 3'd5,
      CSR_STOPS_6_7  = 3'd6
   } csr_index_type;

   // How a sample picks its color
   typedef enum logic [1:0] {
      MODE_FIRST = 2'd0,
      MODE_LAST  = 2'd1,
      MODE_BLEND = 2'd2
   } mode_type;

   typedef struct packed {
      logic     valid;
      mode_type mode;
   } ctl_type;

   typedef logic [STOP_REGS-1:0][CSR_DATA_BITS-1:0] stop_regs_type;

   // Fetch one 24-bit RGB stop from the packed stop registers
   function automatic logic [COLOR_BITS-1:0] get_stop(
      input stop_regs_type           regs,
      input logic [STOP_IDX_BITS-1:0] k
   );
      logic [CSR_DATA_BITS-1:0] reg_word;
      begin
         reg_word = regs[k[STOP_IDX_BITS-1:1]];
         get_stop = k[0] ? reg_word[CSR_DATA_BITS-1:COLOR_BITS]
                         : reg_word[COLOR_BITS-1:0];
      end
   endfunction

endpackage
`default_nettype wire

// ===== rtl/gcm_divider.sv =====
// Pipelined restoring divider: produces the Q0.16 fraction rem/span.
`default_nettype none
module gcm_divider
   import gcm_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ctl_type                in_ctl,
   input  wire logic [REM_BITS-1:0]    in_rem,
   input  wire logic [SAMPLE_BITS-1:0] in_span,
   output ctl_type                     out_ctl,
   output logic [FRAC_BITS-1:0]        out_quot
);

   ctl_type                  ctl_ff  [DIV_STAGES];
   logic [REM_BITS-1:0]      rem_ff  [DIV_STAGES];
   logic [SAMPLE_BITS-1:0]   span_ff [DIV_STAGES];
   logic [FRAC_BITS-1:0]     quot_ff [DIV_STAGES];

   logic [REM_BITS-1:0]      rem_in  [DIV_STAGES];
   logic [FRAC_BITS-1:0]     quot_in [DIV_STAGES];

   // Resolve two quotient bits per stage
   always_comb begin
      logic [REM_BITS-1:0]    r;
      logic [FRAC_BITS-1:0]   q;
      logic [SAMPLE_BITS-1:0] s;
      for (int k = 0; k < DIV_STAGES; k++) begin
         r = (k == 0) ? in_rem  : rem_ff[(k == 0) ? 0 : k - 1];
         q = (k == 0) ? '0      : quot_ff[(k == 0) ? 0 : k - 1];
         s = (k == 0) ? in_span : span_ff[(k == 0) ? 0 : k - 1];
         for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
            r = {r[REM_BITS-2:0], 1'b0};
            q = {q[FRAC_BITS-2:0], 1'b0};
            if (r >= {1'b0, s}) begin
               r    = r - {1'b0, s};
               q[0] = 1'b1;
            end
         end
         rem_in[k]  = r;
         quot_in[k] = q;
      end
   end

   // Advance control with reset
   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (reset) begin
            ctl_ff[k] <= '{valid: 1'b0, mode: MODE_FIRST};
         end else begin
            ctl_ff[k] <= (k == 0) ? in_ctl : ctl_ff[(k == 0) ? 0 : k - 1];
         end
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         rem_ff[k]  <= rem_in[k];
         quot_ff[k] <= quot_in[k];
         span_ff[k] <= (k == 0) ? in_span : span_ff[(k == 0) ? 0 : k - 1];
      end
   end

   assign out_ctl  = ctl_ff[DIV_STAGES-1];
   assign out_quot = quot_ff[DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== rtl/gcm_blend.sv =====
// Segment selection and per-channel linear blend with rounding.
`default_nettype none
module gcm_blend
   import gcm_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire ctl_type                  in_ctl,
   input  wire logic [FRAC_BITS-1:0]     in_quot,
   input  wire logic [STOP_IDX_BITS-1:0] seg_count,
   input  wire stop_regs_type            stops,
   output logic                          out_valid,
   output logic [CHAN_BITS-1:0]          out_red,
   output logic [CHAN_BITS-1:0]          out_green,
   output logic [CHAN_BITS-1:0]          out_blue
);

   localparam int PROD_BITS = CHAN_BITS + FRAC_BITS + 1;
   localparam int CHANNELS  = 3;

   ctl_type                    a_ctl_ff;
   logic [SCALED_BITS-1:0]     a_scaled_ff;
   logic                       b_valid_ff;
   logic [COLOR_BITS-1:0]      b_lo_ff;
   logic [COLOR_BITS-1:0]      b_hi_ff;
   logic [FRAC_BITS-1:0]       b_blend_ff;
   logic                       c_valid_ff;
   logic [PROD_BITS-1:0]       c_plo_ff [CHANNELS];
   logic [PROD_BITS-1:0]       c_phi_ff [CHANNELS];
   logic                       d_valid_ff;
   logic [CHAN_BITS-1:0]       d_chan_ff [CHANNELS];

   logic [STOP_IDX_BITS-1:0]   b_idx_in;
   logic [FRAC_BITS-1:0]       b_blend_in;
   logic [PROD_BITS-1:0]       c_plo_in [CHANNELS];
   logic [PROD_BITS-1:0]       c_phi_in [CHANNELS];
   logic [CHAN_BITS-1:0]       d_chan_in [CHANNELS];

   // Pick the segment and blend weight
   always_comb begin
      logic [STOP_IDX_BITS-1:0] seg;
      seg = a_scaled_ff[SCALED_BITS-1:FRAC_BITS];
      case (a_ctl_ff.mode)
         MODE_BLEND: begin
            b_idx_in   = (seg > seg_count - 1'b1) ? seg_count - 1'b1 : seg;
            b_blend_in = a_scaled_ff[FRAC_BITS-1:0];
         end
         MODE_LAST: begin
            b_idx_in   = seg_count;
            b_blend_in = '0;
         end
         default: begin
            b_idx_in   = '0;
            b_blend_in = '0;
         end
      endcase
   end

   // Weight both stops per channel
   always_comb begin
      logic [FRAC_BITS:0] w_lo;
      w_lo = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, b_blend_ff};
      for (int ch = 0; ch < CHANNELS; ch++) begin
         c_plo_in[ch] = PROD_BITS'(b_lo_ff[ch*CHAN_BITS +: CHAN_BITS] * w_lo);
         c_phi_in[ch] = PROD_BITS'(b_hi_ff[ch*CHAN_BITS +: CHAN_BITS] * b_blend_ff);
      end
   end

   // Sum and round to nearest
   always_comb begin
      logic [PROD_BITS:0] sum;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         sum = {1'b0, c_plo_ff[ch]} + {1'b0, c_phi_ff[ch]}
               + (PROD_BITS+1)'(1 << (FRAC_BITS - 1));
         d_chan_in[ch] = sum[FRAC_BITS +: CHAN_BITS];
      end
   end

   // Advance control with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff   <= '{valid: 1'b0, mode: MODE_FIRST};
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         a_ctl_ff   <= in_ctl;
         b_valid_ff <= a_ctl_ff.valid;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      a_scaled_ff <= SCALED_BITS'(in_quot * seg_count);
      b_lo_ff     <= get_stop(stops, b_idx_in);
      b_hi_ff     <= get_stop(stops, b_idx_in + 1'b1);
      b_blend_ff  <= b_blend_in;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         c_plo_ff[ch]  <= c_plo_in[ch];
         c_phi_ff[ch]  <= c_phi_in[ch];
         d_chan_ff[ch] <= d_chan_in[ch];
      end
   end

   assign out_valid = d_valid_ff;
   assign out_blue  = d_chan_ff[0];
   assign out_green = d_chan_ff[1];
   assign out_red   = d_chan_ff[2];

endmodule
`default_nettype wire

// ===== rtl/gradient_color_map.sv =====
// Gradient color map: one sample in per cycle, one RGB transaction out per sample.
// Pipeline: rsp_valid rises from the last of 13 register stages
// (1 range stage, 8 divider stages at two quotient bits each, 4 blend stages).
// Throughput: one transaction per cycle, every cycle; busy stays low.
// Reset: synchronous, clears all valid bits and restores the default
// black-to-white gradient over 0 .. 8388607; the receiver cannot stall.
`default_nettype none
module gradient_color_map
   import gcm_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [SAMPLE_BITS-1:0]   req_sample_value,
   output logic                          rsp_valid,
   output logic [CHAN_BITS-1:0]          rsp_red,
   output logic [CHAN_BITS-1:0]          rsp_green,
   output logic [CHAN_BITS-1:0]          rsp_blue,
   input  wire logic                     csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_data
);

   logic [SAMPLE_BITS-1:0]   range_min_ff;
   logic [SAMPLE_BITS-1:0]   range_max_ff;
   logic [COUNT_BITS-1:0]    stop_count_ff;
   stop_regs_type            stops_ff;

   ctl_type                  s0_ctl_ff;
   logic [REM_BITS-1:0]      s0_rem_ff;
   logic [SAMPLE_BITS-1:0]   s0_span_ff;
   ctl_type                  s0_ctl_in;
   logic [REM_BITS-1:0]      s0_rem_in;
   logic [SAMPLE_BITS-1:0]   s0_span_in;

   logic [STOP_IDX_BITS-1:0] seg_count;
   ctl_type                  div_ctl;
   logic [FRAC_BITS-1:0]     div_quot;

   assign busy = 1'b0;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         range_min_ff  <= '0;
         range_max_ff  <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         stop_count_ff <= COUNT_BITS'(2);
         stops_ff      <= {{((STOP_REGS-1)*CSR_DATA_BITS){1'b0}},
                           {COLOR_BITS{1'b1}}, {COLOR_BITS{1'b0}}};
      end else if (csr_we) begin
         case (csr_index)
            CSR_RANGE_MIN:  range_min_ff  <= csr_data[SAMPLE_BITS-1:0];
            CSR_RANGE_MAX:  range_max_ff  <= csr_data[SAMPLE_BITS-1:0];
            CSR_STOP_COUNT: stop_count_ff <= csr_data[COUNT_BITS-1:0];
            CSR_STOPS_0_1:  stops_ff[0]   <= csr_data;
            CSR_STOPS_2_3:  stops_ff[1]   <= csr_data;
            CSR_STOPS_4_5:  stops_ff[2]   <= csr_data;
            CSR_STOPS_6_7:  stops_ff[3]   <= csr_data;
            default: ;
         endcase
      end
   end

   // Clamp the stop count to 1..MAX_STOPS and keep segments = count - 1
   always_comb begin
      if (stop_count_ff == '0) begin
         seg_count = '0;
      end else if (stop_count_ff > COUNT_BITS'(MAX_STOPS)) begin
         seg_count = STOP_IDX_BITS'(MAX_STOPS - 1);
      end else begin
         seg_count = STOP_IDX_BITS'(stop_count_ff - 1'b1);
      end
   end

   // Classify the sample against the range and form divider operands
   always_comb begin
      logic signed [SAMPLE_BITS:0] v;
      logic signed [SAMPLE_BITS:0] lo;
      logic signed [SAMPLE_BITS:0] hi;
      logic signed [SAMPLE_BITS:0] diff;
      logic signed [SAMPLE_BITS:0] span;
      v    = {req_sample_value[SAMPLE_BITS-1], req_sample_value};
      lo   = {range_min_ff[SAMPLE_BITS-1], range_min_ff};
      hi   = {range_max_ff[SAMPLE_BITS-1], range_max_ff};
      diff = v - lo;
      span = hi - lo;
      s0_ctl_in.valid = start;
      if (seg_count == '0 || v <= lo) begin
         s0_ctl_in.mode = MODE_FIRST;
      end else if (v >= hi) begin
         s0_ctl_in.mode = MODE_LAST;
      end else begin
         s0_ctl_in.mode = MODE_BLEND;
      end
      s0_rem_in  = {1'b0, diff[SAMPLE_BITS-1:0]};
      s0_span_in = span[SAMPLE_BITS-1:0];
   end

   // Capture the accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ctl_ff <= '{valid: 1'b0, mode: MODE_FIRST};
      end else begin
         s0_ctl_ff <= s0_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      s0_rem_ff  <= s0_rem_in;
      s0_span_ff <= s0_span_in;
   end

   gcm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (s0_ctl_ff),
      .in_rem   (s0_rem_ff),
      .in_span  (s0_span_ff),
      .out_ctl  (div_ctl),
      .out_quot (div_quot)
   );

   gcm_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (div_ctl),
      .in_quot   (div_quot),
      .seg_count (seg_count),
      .stops     (stops_ff),
      .out_valid (rsp_valid),
      .out_red   (rsp_red),
      .out_green (rsp_green),
      .out_blue  (rsp_blue)
   );

endmodule
`default_nettype wire
